[rtl/epp_pkg.sv]
// Shared widths, register indexes and types for the ellipse point placer.
package epp_pkg;

    localparam int IDX_W           = 10;
    localparam int CNT_W           = 11;
    localparam int N_W             = 9;
    localparam int CE_W            = 12;
    localparam int CN_W            = 22;
    localparam int NN_W            = 18;
    localparam int P_W             = 24;
    localparam int F_W             = 25;
    localparam int CRD_W           = 32;
    localparam int DIFF_W          = 33;
    localparam int PROD_W          = 58;
    localparam int NUM_W           = 59;
    localparam int DEN_W           = 25;
    localparam int CFG_IDX_W       = 3;
    localparam int MAX_HOSTS_DEF   = 1024;
    localparam int COORD_WIDTH_DEF = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X    = 3'd0,
        CFG_MIN_Y    = 3'd1,
        CFG_MAX_X    = 3'd2,
        CFG_MAX_Y    = 3'd3,
        CFG_HOSTS    = 3'd4,
        CFG_HEIGHT   = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic valid;
        logic bad;
        logic neg_x;
        logic neg_y;
    } t_geom_ctl;

endpackage

[rtl/ellipse_point_placer.sv]
// Top level of the ellipse point placer: config registers, dividers, output word.
//
// Input channel: i_valid / o_stall carry i_host_index; a word is taken at a
// rising edge with i_valid high and o_stall low. Output channel: o_valid /
// i_stall carry o_pos_x, o_pos_y, o_pos_z and o_bad_request.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_index (min x, min y,
// max x, max y, host count, height); write only while no word is in flight.
// The pipeline is 6 geometry stages, 59 divider stages (one quotient bit
// each) and the output register. One word enters per cycle unless stalled.
// Reset (synchronous, active low) empties the pipeline, sets host count
// to 4 and the other registers to 0.
// While the output word is held by i_stall, the whole pipeline holds and
// o_stall is raised; nothing is dropped or repeated.
// A bad host count, an index out of range or a flat rectangle gives a
// zero position with o_bad_request set.
module ellipse_point_placer #(
    parameter int MAX_HOSTS   = epp_pkg::MAX_HOSTS_DEF,
    parameter int COORD_WIDTH = epp_pkg::COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [epp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [epp_pkg::CRD_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [epp_pkg::IDX_W-1:0]       i_host_index,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [epp_pkg::CRD_W-1:0] o_pos_x,
    output logic signed [epp_pkg::CRD_W-1:0] o_pos_y,
    output logic signed [epp_pkg::CRD_W-1:0] o_pos_z,
    output logic                            o_bad_request
);
    import epp_pkg::*;

    localparam int SAT_BITS = (COORD_WIDTH < CRD_W) ? COORD_WIDTH : CRD_W;
    localparam int RES_W    = NUM_W + 2;
    localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
    localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

    logic signed [CRD_W-1:0] r_min_x, r_min_y, r_max_x, r_max_y, r_height;
    logic [CNT_W-1:0]        r_host_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x      <= '0;
            r_min_y      <= '0;
            r_max_x      <= '0;
            r_max_y      <= '0;
            r_host_count <= CNT_W'(4);
            r_height     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_X:  r_min_x      <= i_cfg_data;
                CFG_MIN_Y:  r_min_y      <= i_cfg_data;
                CFG_MAX_X:  r_max_x      <= i_cfg_data;
                CFG_MAX_Y:  r_max_y      <= i_cfg_data;
                CFG_HOSTS:  r_host_count <= i_cfg_data[CNT_W-1:0];
                CFG_HEIGHT: r_height     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    logic r_out_valid;

    assign adv     = ~(r_out_valid & i_stall);
    assign o_stall = ~adv;

    t_geom_ctl        geom_ctl;
    logic [NUM_W-1:0] num_x, num_y, quo_x, quo_y;
    logic [DEN_W-1:0] den;

    epp_geom #(
        .MAX_HOSTS (MAX_HOSTS)
    ) u_geom (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_valid      (i_valid),
        .i_host_index (i_host_index),
        .i_host_count (r_host_count),
        .i_min_x      (r_min_x),
        .i_min_y      (r_min_y),
        .i_max_x      (r_max_x),
        .i_max_y      (r_max_y),
        .o_ctl        (geom_ctl),
        .o_num_x      (num_x),
        .o_num_y      (num_y),
        .o_den        (den)
    );

    epp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_x (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (num_x),
        .i_den (den),
        .o_quo (quo_x)
    );

    epp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_y (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (num_y),
        .i_den (den),
        .o_quo (quo_y)
    );

    t_geom_ctl r_ctl [NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_W; i++) begin
                r_ctl[i] <= '0;
            end
        end else if (adv) begin
            r_ctl[0] <= geom_ctl;
            for (int i = 1; i < NUM_W; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    t_geom_ctl               ctl_last;
    logic signed [RES_W-1:0] qx, qy, sx, sy, satx, saty;

    assign ctl_last = r_ctl[NUM_W-1];
    assign qx = ctl_last.neg_x ? -$signed(RES_W'(quo_x)) : $signed(RES_W'(quo_x));
    assign qy = ctl_last.neg_y ? -$signed(RES_W'(quo_y)) : $signed(RES_W'(quo_y));
    assign sx = qx + RES_W'(r_min_x);
    assign sy = qy + RES_W'(r_min_y);

    always_comb begin
        if (sx > SAT_HI) begin
            satx = SAT_HI;
        end else if (sx < SAT_LO) begin
            satx = SAT_LO;
        end else begin
            satx = sx;
        end
        if (sy > SAT_HI) begin
            saty = SAT_HI;
        end else if (sy < SAT_LO) begin
            saty = SAT_LO;
        end else begin
            saty = sy;
        end
    end

    logic signed [CRD_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic                    r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= ctl_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_bad   <= ctl_last.bad;
            r_pos_x <= ctl_last.bad ? '0 : satx[CRD_W-1:0];
            r_pos_y <= ctl_last.bad ? '0 : saty[CRD_W-1:0];
            r_pos_z <= ctl_last.bad ? '0 : r_height;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_pos_z       = r_pos_z;
    assign o_bad_request = r_bad;

endmodule

[rtl/epp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module epp_div #(
    parameter int NUM_W = 59,
    parameter int DEN_W = 25
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             qbit;

        if (g == 0) begin : g_first
            assign rem_in = '0;
            assign den_in = i_den;
            assign num_in = i_num;
        end else begin : g_rest
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign num_in = r_num[g-1];
        end

        assign trial = {rem_in, num_in[NUM_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign qbit  = ~diff[DEN_W];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_num[g] <= {num_in[NUM_W-2:0], qbit};
                r_den[g] <= den_in;
            end
        end
    end

    assign o_quo = r_num[NUM_W-1];

endmodule

[rtl/epp_geom.sv]
// Front pipeline: quadrant split, line coefficients, numerators and divisor.
module epp_geom #(
    parameter int MAX_HOSTS = epp_pkg::MAX_HOSTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [epp_pkg::IDX_W-1:0]    i_host_index,
    input  logic [epp_pkg::CNT_W-1:0]    i_host_count,
    input  logic signed [epp_pkg::CRD_W-1:0] i_min_x,
    input  logic signed [epp_pkg::CRD_W-1:0] i_min_y,
    input  logic signed [epp_pkg::CRD_W-1:0] i_max_x,
    input  logic signed [epp_pkg::CRD_W-1:0] i_max_y,
    output epp_pkg::t_geom_ctl           o_ctl,
    output logic [epp_pkg::NUM_W-1:0]    o_num_x,
    output logic [epp_pkg::NUM_W-1:0]    o_num_y,
    output logic [epp_pkg::DEN_W-1:0]    o_den
);
    import epp_pkg::*;

    logic signed [DIFF_W-1:0] w;
    logic signed [DIFF_W-1:0] h;
    logic [N_W-1:0]   n;
    logic [CNT_W-1:0] n1, n2, n3, idx;
    logic [1:0]       quad;
    logic [N_W-1:0]   k;
    logic             bad;

    assign w   = $signed({i_max_x[CRD_W-1], i_max_x}) - $signed({i_min_x[CRD_W-1], i_min_x});
    assign h   = $signed({i_max_y[CRD_W-1], i_max_y}) - $signed({i_min_y[CRD_W-1], i_min_y});
    assign n   = i_host_count[CNT_W-1:2];
    assign n1  = {2'b00, n};
    assign n2  = {1'b0, n, 1'b0};
    assign n3  = n1 + n2;
    assign idx = {1'b0, i_host_index};

    always_comb begin
        if (idx >= n3) begin
            quad = 2'd3;
            k    = N_W'(idx - n3);
        end else if (idx >= n2) begin
            quad = 2'd2;
            k    = N_W'(idx - n2);
        end else if (idx >= n1) begin
            quad = 2'd1;
            k    = N_W'(idx - n1);
        end else begin
            quad = 2'd0;
            k    = N_W'(idx);
        end
    end

    assign bad = (i_host_count == '0) || (i_host_count[1:0] != 2'b00)
              || ({21'd0, i_host_count} > 32'(MAX_HOSTS))
              || (idx >= i_host_count) || (w == '0) || (h == '0);

    // stage 1
    logic           r1_valid, r1_bad;
    logic [1:0]     r1_quad;
    logic [N_W-1:0] r1_k, r1_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_bad  <= bad;
            r1_quad <= quad;
            r1_k    <= k;
            r1_n    <= n;
        end
    end

    // stage 2
    logic signed [CE_W-1:0] k2, nn2, c, e;
    logic signed [CE_W-1:0] r2_c, r2_e;
    logic                   r2_valid, r2_bad, r2_qxp, r2_qyp;
    logic [N_W-1:0]         r2_n;

    assign k2  = $signed({2'b00, r1_k, 1'b0});
    assign nn2 = $signed({2'b00, r1_n, 1'b0});

    always_comb begin
        case (r1_quad)
            2'd0: begin
                c = k2;
                e = k2;
            end
            2'd1: begin
                c = nn2 - k2;
                e = k2 - nn2;
            end
            2'd2: begin
                c = -k2;
                e = -k2;
            end
            default: begin
                c = k2 - nn2;
                e = nn2 - k2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_bad <= r1_bad;
            r2_c   <= c;
            r2_e   <= e;
            r2_n   <= r1_n;
            r2_qxp <= (r1_quad == 2'd1) || (r1_quad == 2'd2);
            r2_qyp <= (r1_quad == 2'd0) || (r1_quad == 2'd1);
        end
    end

    // stage 3
    logic signed [P_W-1:0]  r3_ce;
    logic [NN_W-1:0]        r3_nn;
    logic signed [CN_W-1:0] r3_cn;
    logic                   r3_valid, r3_bad, r3_qxp, r3_qyp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_bad <= r2_bad;
            r3_ce  <= r2_c * r2_e;
            r3_nn  <= r2_n * r2_n;
            r3_cn  <= r2_c * $signed({1'b0, r2_n});
            r3_qxp <= r2_qxp;
            r3_qyp <= r2_qyp;
        end
    end

    // stage 4
    logic signed [F_W-1:0] n4, ce, cn4, d, fx, fy;

    assign n4  = $signed(F_W'({r3_nn, 2'b00}));
    assign ce  = F_W'(r3_ce);
    assign cn4 = F_W'(r3_cn) <<< 2;
    assign d   = (r3_qxp == r3_qyp) ? ce - n4 : ce + n4;
    assign fx  = d + (r3_qyp ? -n4 : n4) + (r3_qxp ? -ce : ce);
    assign fy  = d + ((r3_qxp == r3_qyp) ? -cn4 : cn4);

    logic signed [F_W-1:0] r4_d, r4_fx, r4_fy;
    logic                  r4_valid, r4_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_bad <= r3_bad;
            r4_d   <= d;
            r4_fx  <= fx;
            r4_fy  <= fy;
        end
    end

    // stage 5
    logic signed [PROD_W-1:0] r5_px, r5_py;
    logic signed [F_W-1:0]    r5_d;
    logic                     r5_valid, r5_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_bad <= r4_bad;
            r5_px  <= w * r4_fx;
            r5_py  <= h * r4_fy;
            r5_d   <= r4_d;
        end
    end

    // stage 6
    logic [PROD_W-1:0] ax, ay;
    logic [F_W-1:0]    ad;

    assign ax = r5_px[PROD_W-1] ? PROD_W'(-r5_px) : PROD_W'(r5_px);
    assign ay = r5_py[PROD_W-1] ? PROD_W'(-r5_py) : PROD_W'(r5_py);
    assign ad = r5_d[F_W-1] ? F_W'(-r5_d) : F_W'(r5_d);

    logic              r6_valid, r6_bad, r6_negx, r6_negy;
    logic [NUM_W-1:0]  r6_num_x, r6_num_y;
    logic [DEN_W-1:0]  r6_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_bad   <= r5_bad;
            r6_negx  <= r5_px[PROD_W-1] ^ r5_d[F_W-1];
            r6_negy  <= r5_py[PROD_W-1] ^ r5_d[F_W-1];
            r6_num_x <= NUM_W'(ax) + NUM_W'(ad);
            r6_num_y <= NUM_W'(ay) + NUM_W'(ad);
            r6_den   <= DEN_W'({ad, 1'b0});
        end
    end

    assign o_ctl.valid = r6_valid;
    assign o_ctl.bad   = r6_bad;
    assign o_ctl.neg_x = r6_negx;
    assign o_ctl.neg_y = r6_negy;
    assign o_num_x     = r6_num_x;
    assign o_num_y     = r6_num_y;
    assign o_den       = r6_den;

endmodule
